// ===== rtl/core/gvf_pkg.sv =====
// ----------------------------------------------------------------------------
// gvf_pkg
// shared widths, constants and a magnitude helper of the volatility filter
// ----------------------------------------------------------------------------
`default_nettype none

package gvf_pkg;

   localparam int DATA_W = 48;
   localparam int COEF_W = 32;
   localparam int VAR_FRAC = 44;
   localparam int COEF_FRAC = 28;
   localparam int MUL_W = 64;
   localparam int CSR_IDX_W = 3;

   // variance constants in q4.44
   localparam logic [DATA_W-1:0] K_1E12 = 48'd18;
   localparam logic [DATA_W-1:0] K_1E6 = 48'd17592186;
   localparam logic [DATA_W-1:0] K_1E8 = 48'd175922;
   localparam logic [DATA_W-1:0] VAR_MAX = {DATA_W{1'b1}};

   // model codes
   localparam logic [2:0] MODE_GARCH = 3'd0;
   localparam logic [2:0] MODE_GJR = 3'd1;
   localparam logic [2:0] MODE_NAGARCH = 3'd2;
   localparam logic [2:0] MODE_SHIFTED = 3'd3;
   localparam logic [2:0] MODE_IGARCH = 3'd4;
   localparam logic [2:0] MODE_CONST = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OMEGA = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BETA = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAMMA = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MEAN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_START = 3'd7;

   // magnitude of a signed word
   function automatic logic [MUL_W-1:0] mag64(input logic signed [MUL_W-1:0] x);
      mag64 = x[MUL_W-1] ? MUL_W'(-x) : MUL_W'(x);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gvf_req_if.sv =====
// ----------------------------------------------------------------------------
// gvf_req_if
// request channel: one return sample and its series start mark
// ----------------------------------------------------------------------------
`default_nettype none

interface gvf_req_if;
   logic valid;
   logic ready;
   logic signed [47:0] return_value;
   logic series_start;

   modport source (output valid, output return_value, output series_start, input ready);
   modport sink (input valid, input return_value, input series_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gvf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gvf_rsp_if
// result channel: conditional sd and floor-or-saturate flag
// ----------------------------------------------------------------------------
`default_nettype none

interface gvf_rsp_if;
   logic valid;
   logic ready;
   logic [47:0] cond_sd;
   logic var_floored;

   modport source (output valid, output cond_sd, output var_floored, input ready);
   modport sink (input valid, input cond_sd, input var_floored, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gvf_mul.sv =====
// ----------------------------------------------------------------------------
// gvf_mul
// 64x64 unsigned multiplier, 16 bits of b per cycle, four steps
// ----------------------------------------------------------------------------
`default_nettype none

module gvf_mul import gvf_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [MUL_W-1:0]   a_in,
   input  wire logic [MUL_W-1:0]   b_in,
   output logic                    done,
   output logic [2*MUL_W-1:0]      prod
);

   logic [MUL_W-1:0] a_ff, b_ff, b_in_nx, a_in_nx;
   logic [MUL_W-1:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [MUL_W+15:0] step_sum;

   // one partial product per cycle, accumulator shifts right
   always_comb begin
      step_sum = {16'b0, hi_ff} + (a_ff * b_ff[15:0]);
      a_in_nx = a_ff;
      b_in_nx = b_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in_nx = a_in;
         b_in_nx = b_in;
         hi_in = '0;
         lo_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in = step_sum[MUL_W+15:16];
         lo_in = {step_sum[15:0], lo_ff[MUL_W-1:16]};
         b_in_nx = {16'b0, b_ff[MUL_W-1:16]};
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in_nx;
      b_ff <= b_in_nx;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};

endmodule

`default_nettype wire

// ===== rtl/core/garch_family_volatility_filter.sv =====
// the constant model only takes the square root; an ordinary item also runs the variance update,
// and a shock that carries an sd shift (nagarch, shifted threshold) adds one multiply more
// a series start outside igarch may add the 77-step divide; nagarch adds two multiplies before it
// most of the work per item lies in the 46-step serial square root and the shared multiplies
// one request at a time; the next is taken once the result sits in the output register
// synchronous active-high reset clears configuration, variance and control
// ----------------------------------------------------------------------------
// garch_family_volatility_filter
// conditional variance recursion with reload, floor and serial square root
// ----------------------------------------------------------------------------
`default_nettype none

module garch_family_volatility_filter import gvf_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   gvf_req_if.sink                     req,
   gvf_rsp_if.source                   rsp,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [DATA_W-1:0]      csr_wr_data
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_NG2 = 4'd1;
   localparam logic [3:0] S_NX = 4'd2;
   localparam logic [3:0] S_UCALC = 4'd3;
   localparam logic [3:0] S_DIVSET = 4'd4;
   localparam logic [3:0] S_DIV = 4'd5;
   localparam logic [3:0] S_ROOTSET = 4'd6;
   localparam logic [3:0] S_ROOT = 4'd7;
   localparam logic [3:0] S_SHK = 4'd8;
   localparam logic [3:0] S_SQ = 4'd9;
   localparam logic [3:0] S_T1 = 4'd10;
   localparam logic [3:0] S_T2 = 4'd11;
   localparam logic [3:0] S_SUM = 4'd12;
   localparam logic [3:0] S_OUT = 4'd13;

   // configuration registers
   logic [2:0] mode_ff;
   logic [DATA_W-1:0] omega_ff, isv_ff;
   logic signed [COEF_W-1:0] alpha_ff, beta_ff, gamma_ff, shf_ff;
   logic signed [DATA_W-1:0] mu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         omega_ff <= '0;
         alpha_ff <= '0;
         beta_ff <= '0;
         gamma_ff <= '0;
         mu_ff <= '0;
         shf_ff <= '0;
         isv_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_MODE:  mode_ff <= csr_wr_data[2:0];
            REG_OMEGA: omega_ff <= csr_wr_data;
            REG_ALPHA: alpha_ff <= csr_wr_data[COEF_W-1:0];
            REG_BETA:  beta_ff <= csr_wr_data[COEF_W-1:0];
            REG_GAMMA: gamma_ff <= csr_wr_data[COEF_W-1:0];
            REG_MEAN:  mu_ff <= csr_wr_data;
            REG_SHIFT: shf_ff <= csr_wr_data[COEF_W-1:0];
            REG_START: isv_ff <= csr_wr_data;
            default:   mode_ff <= mode_ff;
         endcase
      end
   end

   // datapath registers
   logic [3:0] state_ff, state_in;
   logic [DATA_W-1:0] var_ff, var_in, h_ff, h_in, sd_ff, sd_in;
   logic signed [DATA_W:0] eps_ff, eps_in;
   logic signed [MUL_W-1:0] shock_ff, shock_in, tmp_ff, tmp_in, t1_ff, t1_in, t2_ff, t2_in;
   logic [MUL_W-1:0] sq_ff, sq_in;
   logic [91:0] rad_ff, rad_in;
   logic [45:0] root_ff, root_in;
   logic [49:0] rem_ff, rem_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [76:0] dvd_ff, dvd_in;
   logic [DATA_W-1:0] d_ff, d_in, q_ff, q_in;
   logic sat_ff, sat_in, pend_ff, pend_in;
   logic rsp_valid_ff, rsp_valid_in, flag_ff, flag_in;
   logic [DATA_W-1:0] rsp_sd_ff, rsp_sd_in;
   logic rsp_flag_ff, rsp_flag_in;

   // shared multiplier hookup
   logic mul_start, mul_done, mul_neg, mul_sh44;
   logic [MUL_W-1:0] mul_a, mul_b, mul_mag;
   logic [2*MUL_W-1:0] mul_prod;
   logic signed [MUL_W-1:0] mul_res;

   gvf_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a_in   (mul_a),
      .b_in   (mul_b),
      .done   (mul_done),
      .prod   (mul_prod)
   );

   // sign-extended coefficients
   logic signed [MUL_W-1:0] al64, be64, ga64, sh64, coef64;
   assign al64 = MUL_W'(alpha_ff);
   assign be64 = MUL_W'(beta_ff);
   assign ga64 = MUL_W'(gamma_ff);
   assign sh64 = MUL_W'(shf_ff);
   assign coef64 = (((mode_ff == MODE_GJR) || (mode_ff == MODE_SHIFTED)) && eps_ff[DATA_W])
                   ? al64 + ga64 : al64;

   // truncated product, toward zero
   assign mul_mag = mul_sh44 ? mul_prod[VAR_FRAC+MUL_W-1:VAR_FRAC]
                             : mul_prod[COEF_FRAC+MUL_W-1:COEF_FRAC];
   assign mul_res = mul_neg ? -$signed(mul_mag) : $signed(mul_mag);

   logic signed [MUL_W-1:0] d_calc, sum_calc, shk_coef;
   logic [DATA_W-1:0] h_use, h_clip;
   logic [49:0] rem_try;
   logic [47:0] trial;
   logic [DATA_W-1:0] drem_try;

   always_comb begin
      state_in = state_ff;
      var_in = var_ff;
      h_in = h_ff;
      sd_in = sd_ff;
      eps_in = eps_ff;
      shock_in = shock_ff;
      tmp_in = tmp_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      sq_in = sq_ff;
      rad_in = rad_ff;
      root_in = root_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      d_in = d_ff;
      q_in = q_ff;
      sat_in = sat_ff;
      pend_in = pend_ff;
      flag_in = flag_ff;
      rsp_sd_in = rsp_sd_ff;
      rsp_flag_in = rsp_flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      mul_start = 1'b0;
      mul_a = '0;
      mul_b = '0;
      mul_neg = 1'b0;
      mul_sh44 = 1'b0;
      shk_coef = (mode_ff == MODE_NAGARCH) ? ga64 : sh64;
      d_calc = (MUL_W'(1) <<< (COEF_FRAC + 1)) - tmp_ff;
      sum_calc = ((mode_ff == MODE_IGARCH) ? '0 : $signed({16'b0, omega_ff})) + t1_ff + t2_ff;
      h_use = (var_ff == '0) ? K_1E6 : var_ff;
      h_clip = (mode_ff >= MODE_CONST) ? ((omega_ff < K_1E12) ? K_1E12 : omega_ff)
                                       : ((h_use < K_1E12) ? K_1E12 : h_use);
      rem_try = {rem_ff[47:0], rad_ff[91:90]};
      trial = {root_ff, 2'b01};
      drem_try = {rem_ff[DATA_W-2:0], dvd_ff[76]};

      // operand select for the shared multiplier
      case (state_ff)
         S_NG2: begin
            mul_a = mag64(ga64);
            mul_b = mag64(ga64);
         end
         S_NX: begin
            mul_a = mag64(al64);
            mul_b = tmp_ff;
            mul_neg = al64[MUL_W-1];
         end
         S_SHK: begin
            mul_a = mag64(shk_coef);
            mul_b = {16'b0, sd_ff};
            mul_neg = shk_coef[MUL_W-1];
         end
         S_SQ: begin
            mul_a = mag64(shock_ff);
            mul_b = mag64(shock_ff);
            mul_sh44 = 1'b1;
         end
         S_T1: begin
            mul_a = mag64(coef64);
            mul_b = sq_ff;
            mul_neg = coef64[MUL_W-1];
         end
         S_T2: begin
            mul_a = mag64(be64);
            mul_b = {16'b0, h_ff};
            mul_neg = be64[MUL_W-1];
         end
         default: mul_a = '0;
      endcase

      // multiplier handshake: issue once, wait for done
      if (state_ff inside {S_NG2, S_NX, S_SHK, S_SQ, S_T1, S_T2}) begin
         if (!pend_ff) begin
            mul_start = 1'b1;
            pend_in = 1'b1;
         end else if (mul_done) begin
            pend_in = 1'b0;
         end
      end

      // sequencer
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               eps_in = $signed({req.return_value[DATA_W-1], req.return_value})
                        - $signed({mu_ff[DATA_W-1], mu_ff});
               if (mode_ff >= MODE_CONST) begin
                  state_in = S_ROOTSET;
               end else if (req.series_start) begin
                  case (mode_ff)
                     MODE_IGARCH: begin
                        var_in = (isv_ff > K_1E12) ? isv_ff : K_1E6;
                        state_in = S_ROOTSET;
                     end
                     MODE_NAGARCH: state_in = S_NG2;
                     default: state_in = S_UCALC;
                  endcase
               end else begin
                  state_in = S_ROOTSET;
               end
            end
         end
         S_NG2: begin
            if (pend_ff && mul_done) begin
               tmp_in = (MUL_W'(1) <<< COEF_FRAC) + mul_res;
               state_in = S_NX;
            end
         end
         S_NX: begin
            if (pend_ff && mul_done) begin
               tmp_in = (mul_res <<< 1) + (be64 <<< 1);
               state_in = S_DIVSET;
            end
         end
         S_UCALC: begin
            tmp_in = (mode_ff == MODE_GARCH) ? (al64 <<< 1) + (be64 <<< 1)
                                             : (al64 <<< 1) + ga64 + (be64 <<< 1);
            state_in = S_DIVSET;
         end
         S_DIVSET: begin
            if ((omega_ff != '0) && (d_calc > 0)) begin
               dvd_in = {omega_ff, 29'b0};
               d_in = d_calc[DATA_W-1:0];
               rem_in = '0;
               q_in = '0;
               sat_in = 1'b0;
               cnt_in = 7'd76;
               state_in = S_DIV;
            end else begin
               var_in = omega_ff;
               state_in = S_ROOTSET;
            end
         end
         // restoring divide, one quotient bit per cycle
         S_DIV: begin
            dvd_in = {dvd_ff[75:0], 1'b0};
            if (drem_try >= d_ff) begin
               rem_in = {2'b0, drem_try - d_ff};
               q_in = {q_ff[DATA_W-2:0], 1'b1};
               if (cnt_ff >= 7'(DATA_W))
                  sat_in = 1'b1;
            end else begin
               rem_in = {2'b0, drem_try};
               q_in = {q_ff[DATA_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == '0) begin
               var_in = (sat_in) ? VAR_MAX : q_in;
               state_in = S_ROOTSET;
            end
         end
         S_ROOTSET: begin
            h_in = h_use;
            rad_in = {h_clip, 44'b0};
            root_in = '0;
            rem_in = '0;
            cnt_in = 7'd45;
            state_in = S_ROOT;
         end
         // digit-by-digit square root, one result bit per cycle
         S_ROOT: begin
            rad_in = {rad_ff[89:0], 2'b0};
            if (rem_try >= {2'b0, trial}) begin
               rem_in = rem_try - {2'b0, trial};
               root_in = {root_ff[44:0], 1'b1};
            end else begin
               rem_in = rem_try;
               root_in = {root_ff[44:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == '0) begin
               sd_in = {2'b0, root_in};
               if (mode_ff >= MODE_CONST) begin
                  flag_in = 1'b0;
                  state_in = S_OUT;
               end else if ((mode_ff == MODE_NAGARCH) || (mode_ff == MODE_SHIFTED)) begin
                  state_in = S_SHK;
               end else begin
                  shock_in = MUL_W'(eps_ff);
                  state_in = S_SQ;
               end
            end
         end
         S_SHK: begin
            if (pend_ff && mul_done) begin
               shock_in = MUL_W'(eps_ff) - mul_res;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (pend_ff && mul_done) begin
               sq_in = mul_mag;
               state_in = S_T1;
            end
         end
         S_T1: begin
            if (pend_ff && mul_done) begin
               t1_in = mul_res;
               state_in = S_T2;
            end
         end
         S_T2: begin
            if (pend_ff && mul_done) begin
               t2_in = mul_res;
               state_in = S_SUM;
            end
         end
         // floor and saturate the updated variance
         S_SUM: begin
            if (sum_calc <= 0) begin
               var_in = K_1E8;
               flag_in = 1'b1;
            end else if (sum_calc > $signed({16'b0, VAR_MAX})) begin
               var_in = VAR_MAX;
               flag_in = 1'b1;
            end else begin
               var_in = sum_calc[DATA_W-1:0];
               flag_in = 1'b0;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sd_in = sd_ff;
               rsp_flag_in = flag_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      sd_ff <= sd_in;
      eps_ff <= eps_in;
      shock_ff <= shock_in;
      tmp_ff <= tmp_in;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      sq_ff <= sq_in;
      rad_ff <= rad_in;
      root_ff <= root_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      d_ff <= d_in;
      q_ff <= q_in;
      sat_ff <= sat_in;
      flag_ff <= flag_in;
      rsp_sd_ff <= rsp_sd_in;
      rsp_flag_ff <= rsp_flag_in;
      if (reset) begin
         state_ff <= S_IDLE;
         var_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         var_ff <= var_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.cond_sd = rsp_sd_ff;
   assign rsp.var_floored = rsp_flag_ff;

   // checks
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output step");

   a_mul_done_pending: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> pend_ff)
      else $error("multiplier done without a pending operation");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (state_ff == S_IDLE) && !rsp_valid_ff)
      else $error("not idle after reset");

endmodule

`default_nettype wire
